[hdl/nkck_pkg.sv]
`timescale 1ns / 1ps

package nkck_pkg;

  localparam int KEEP_COUNT_DEFAULT = 6;

  localparam int CODE_W = 40;
  localparam int DIST_W = 32;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 4;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DUMP = 3'b100
  } state_t;

endpackage

[hdl/nkck_if.sv]
`timescale 1ns / 1ps

interface nkck_in_if;
  logic                          valid;
  logic                          ready;
  logic [nkck_pkg::KIND_W-1:0]   kind;
  logic [nkck_pkg::CODE_W-1:0]   code_chars;
  logic [nkck_pkg::DIST_W-1:0]   distance;
  logic [nkck_pkg::WORD_W-1:0]   block_size;
  logic [nkck_pkg::WORD_W-1:0]   block_offset;

  modport source (output valid, kind, code_chars, distance, block_size, block_offset,
                  input ready);
  modport sink (input valid, kind, code_chars, distance, block_size, block_offset,
                output ready);
endinterface

interface nkck_out_if;
  logic                          valid;
  logic                          ready;
  logic [nkck_pkg::SLOT_W-1:0]   slot;
  logic                          entry_valid;
  logic [nkck_pkg::CODE_W-1:0]   out_code_chars;
  logic [nkck_pkg::DIST_W-1:0]   out_distance;
  logic [nkck_pkg::WORD_W-1:0]   out_block_size;
  logic [nkck_pkg::WORD_W-1:0]   out_block_offset;
  logic                          last;

  modport source (output valid, slot, entry_valid, out_code_chars, out_distance,
                  out_block_size, out_block_offset, last, input ready);
  modport sink (input valid, slot, entry_valid, out_code_chars, out_distance,
                out_block_size, out_block_offset, last, output ready);
endinterface

[hdl/nearest_k_candidate_keeper_unit.sv]
`timescale 1ns / 1ps

// Channel  Direction  Payload
// req      sink       kind, code_chars, distance, block_size, block_offset
// rsp      source     slot, entry_valid, out_code_chars, out_distance,
//                     out_block_size, out_block_offset, last
//
// A clear, an ignored kind and an insert into a table that is not full complete when accepted.
// An insert that replaces the worst entry then enters a scan: one distance
// comparator walks all slots to find the new worst. A dump emits one item per held
// entry (one for an empty table) while rsp is ready. Reset empties the table
// at once; the entry store itself is not cleared. A stalled rsp holds its item in the
// output register, and req is accepted again as soon as the sequencer is idle.

module nearest_k_candidate_keeper_unit #(
  parameter int KEEP_COUNT = nkck_pkg::KEEP_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  nkck_in_if.sink           req,
  nkck_out_if.source        rsp
);

  localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int CNT_W = $clog2(KEEP_COUNT + 1);

  nkck_pkg::state_t state;

  logic [CNT_W-1:0]            entry_count;
  logic [IDX_W-1:0]            worst_slot;
  logic [nkck_pkg::DIST_W-1:0] worst_distance;
  logic [IDX_W-1:0]            idx;

  logic [nkck_pkg::CODE_W-1:0] stored_code     [KEEP_COUNT];
  logic [nkck_pkg::DIST_W-1:0] stored_distance [KEEP_COUNT];
  logic [nkck_pkg::WORD_W-1:0] stored_size     [KEEP_COUNT];
  logic [nkck_pkg::WORD_W-1:0] stored_offset   [KEEP_COUNT];

  logic                          out_valid;
  logic [nkck_pkg::SLOT_W-1:0]   out_slot;
  logic                          out_entry_valid;
  logic [nkck_pkg::CODE_W-1:0]   out_code;
  logic [nkck_pkg::DIST_W-1:0]   out_dist;
  logic [nkck_pkg::WORD_W-1:0]   out_size;
  logic [nkck_pkg::WORD_W-1:0]   out_offset;
  logic                          out_last;

  logic                          accept;
  logic                          full;
  logic                          idx_is_last;
  logic                          out_free;
  logic [nkck_pkg::DIST_W-1:0]   cmp_a;
  logic                          cmp_gt;
  logic                          cmp_lt;
  logic [IDX_W-1:0]              write_slot;

  assign accept      = req.valid && req.ready;
  assign full        = (entry_count == CNT_W'(KEEP_COUNT));
  assign idx_is_last = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
  assign out_free    = !out_valid || rsp.ready;
  assign write_slot  = full ? worst_slot : entry_count[IDX_W-1:0];

  // The one comparator: the incoming distance while idle, a stored one while scanning.
  assign cmp_a  = (state == nkck_pkg::ST_SCAN) ? stored_distance[idx] : req.distance;
  assign cmp_gt = (cmp_a > worst_distance);
  assign cmp_lt = (cmp_a < worst_distance);

  assign req.ready = (state == nkck_pkg::ST_IDLE);

  assign rsp.valid            = out_valid;
  assign rsp.slot             = out_slot;
  assign rsp.entry_valid      = out_entry_valid;
  assign rsp.out_code_chars   = out_code;
  assign rsp.out_distance     = out_dist;
  assign rsp.out_block_size   = out_size;
  assign rsp.out_block_offset = out_offset;
  assign rsp.last             = out_last;

  always_ff @(posedge clk) begin
    if (accept && (req.kind == nkck_pkg::KIND_INSERT) && (!full || cmp_lt)) begin
      stored_code[write_slot]     <= req.code_chars;
      stored_distance[write_slot] <= req.distance;
      stored_size[write_slot]     <= req.block_size;
      stored_offset[write_slot]   <= req.block_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= nkck_pkg::ST_IDLE;
      entry_count    <= '0;
      worst_slot     <= '0;
      worst_distance <= '0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !((state == nkck_pkg::ST_DUMP) && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        nkck_pkg::ST_IDLE: begin
          if (accept) begin
            priority case (req.kind)
              nkck_pkg::KIND_INSERT: begin
                if (!full) begin
                  if (cmp_gt) begin
                    worst_distance <= req.distance;
                    worst_slot     <= entry_count[IDX_W-1:0];
                  end
                  entry_count <= entry_count + CNT_W'(1);
                end else if (cmp_lt) begin
                  worst_distance <= '0;
                  idx            <= '0;
                  state          <= nkck_pkg::ST_SCAN;
                end
              end
              nkck_pkg::KIND_CLEAR: begin
                entry_count    <= '0;
                worst_slot     <= '0;
                worst_distance <= '0;
              end
              nkck_pkg::KIND_DUMP: begin
                idx   <= '0;
                state <= nkck_pkg::ST_DUMP;
              end
              default: begin
              end
            endcase
          end
        end
        nkck_pkg::ST_SCAN: begin
          if (cmp_gt) begin
            worst_distance <= stored_distance[idx];
            worst_slot     <= idx;
          end
          if (idx_is_last) begin
            state <= nkck_pkg::ST_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        nkck_pkg::ST_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (entry_count == '0) begin
              out_last <= 1'b1;
              state    <= nkck_pkg::ST_IDLE;
            end else begin
              out_last <= idx_is_last;
              if (idx_is_last) begin
                state <= nkck_pkg::ST_IDLE;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          state <= nkck_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == nkck_pkg::ST_DUMP) && out_free) begin
      if (entry_count == '0) begin
        out_slot        <= '0;
        out_entry_valid <= 1'b0;
        out_code        <= '0;
        out_dist        <= '0;
        out_size        <= '0;
        out_offset      <= '0;
      end else begin
        out_slot        <= nkck_pkg::SLOT_W'(idx);
        out_entry_valid <= 1'b1;
        out_code        <= stored_code[idx];
        out_dist        <= stored_distance[idx];
        out_size        <= stored_size[idx];
        out_offset      <= stored_offset[idx];
      end
    end
  end

endmodule
